@@ rtl/assert_macros.svh @@
// Assertion macros shared by the dust reporter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/hdaqi_pkg.sv @@
// Types, constants and segment tables for the hourly dust AQI reporter.
package hdaqi_pkg;
   localparam int SensorCountDefault = 256;
   localparam int MaxPerHourDefault  = 4095;
   localparam int SampleW = 14;
   localparam int SumW    = 25;
   localparam int HourW   = 5;
   localparam int SensorW = 8;
   localparam int AqiW    = 9;
   localparam int CatW    = 3;
   localparam int ProdW   = 32;
   // the rounding term pushes a saturated sum one bit past SumW
   localparam int DivW    = SumW + 1;

   localparam logic [0:0] CsrValidLow  = 1'b0;
   localparam logic [0:0] CsrValidHigh = 1'b1;
   localparam logic [0:0] KindSample   = 1'b0;
   localparam logic [0:0] KindFlush    = 1'b1;
   localparam logic [0:0] RptAverage   = 1'b0;
   localparam logic [0:0] RptOutlier   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DECIDE, ST_DIV, ST_MUL, ST_AQI, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

   function automatic logic [CatW-1:0] seg_of(input logic [SampleW-1:0] avg);
      logic [CatW-1:0] c;
      c = 3'd0;
      if (avg >= 14'd120)  c = 3'd1;
      if (avg >= 14'd355)  c = 3'd2;
      if (avg >= 14'd555)  c = 3'd3;
      if (avg >= 14'd1505) c = 3'd4;
      if (avg >= 14'd2505) c = 3'd5;
      if (avg >= 14'd3505) c = 3'd6;
      return c;
   endfunction

   function automatic logic [10:0] seg_slope(input logic [CatW-1:0] c);
      logic [10:0] s;
      case (c)
         3'd0:    s = 11'd1067;
         3'd1:    s = 11'd543;
         3'd2:    s = 11'd640;
         3'd3:    s = 11'd133;
         3'd4:    s = 11'd256;
         3'd5:    s = 11'd256;
         default: s = 11'd128;
      endcase
      return s;
   endfunction

   // ten times the offset plus half of the divisor
   function automatic logic [ProdW-1:0] seg_bias(input logic [CatW-1:0] c);
      logic [ProdW-1:0] b;
      case (c)
         3'd0:    b = 32'd1280;
         3'd1:    b = 32'd63900;
         3'd2:    b = 32'd30080;
         3'd3:    b = 32'd310480;
         3'd4:    b = 32'd128000;
         3'd5:    b = 32'd128000;
         default: b = 32'd576640;
      endcase
      return b;
   endfunction
endpackage

@@ rtl/hourly_dust_aqi_reporter.sv @@
// Top level of the hourly dust AQI reporter.
//  channel | direction | handshake        | payload
//  req     | in        | valid / stall    | kind, sensor, hour_of_day, sample
//  rsp     | out       | valid / stall    | report_kind .. category
//  csr     | in        | valid / ready    | index, data
// An item that closes an hour goes through the bit-serial divider for the
// average. After reset a clearing pass walks the sensor memory with
// req_stall high. A stalled result holds in its output register; the next
// item is taken once it leaves.
module hourly_dust_aqi_reporter #(
   parameter int SENSOR_COUNT = hdaqi_pkg::SensorCountDefault,
   parameter int MAX_PER_HOUR = hdaqi_pkg::MaxPerHourDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_kind,
   input  logic [7:0]  req_sensor,
   input  logic [4:0]  req_hour_of_day,
   input  logic [13:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [0:0]  rsp_report_kind,
   output logic [7:0]  rsp_sensor_out,
   output logic [4:0]  rsp_hour_label,
   output logic [13:0] rsp_level,
   output logic [8:0]  rsp_aqi,
   output logic [2:0]  rsp_category,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [13:0] csr_data
);
   import hdaqi_pkg::*;
   `include "assert_macros.svh"

   localparam int AddrW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int CntW  = $clog2(MAX_PER_HOUR + 1);
   localparam int EntW  = HourW + SumW + CntW;

   state_type state_ff, state_in;
   logic [SampleW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AddrW:0] clr_ff, clr_in;
   logic clearing;
   logic [0:0] kind_ff, kind_in;
   logic [SensorW-1:0] sen_ff, sen_in;
   logic [HourW-1:0] hr_ff, hr_in;
   logic [SampleW-1:0] smp_ff, smp_in;
   logic [HourW-1:0] ohr_ff, ohr_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SampleW-1:0] avg_ff, avg_in;
   logic [CatW-1:0] cat_ff, cat_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic ov_ff, ov_in;
   logic [0:0] o_kind_ff, o_kind_in;
   logic [SensorW-1:0] o_sen_ff, o_sen_in;
   logic [HourW-1:0] o_hr_ff, o_hr_in;
   logic [SampleW-1:0] o_lvl_ff, o_lvl_in;
   logic [AqiW-1:0] o_aqi_ff, o_aqi_in;
   logic [CatW-1:0] o_cat_ff, o_cat_in;
   logic o_vld_ff, o_vld_in;

   logic ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [EntW-1:0] ram_wd, ram_rd;
   div_req_type dreq;
   div_rsp_type drsp;
   logic req_take;
   logic [SumW:0] sum_add;
   logic [DivW-1:0] q_sat;
   logic [ProdW-1:0] aqi_full;

   hdaqi_ram #(.Width(EntW), .Depth(2 ** AddrW)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   hdaqi_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign clearing  = (clr_ff != '0);
   assign csr_ready = 1'b1;
   assign req_stall = clearing || (state_ff != ST_IDLE) || o_vld_ff;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lo_ff    <= 14'd50;
         hi_ff    <= 14'd5505;
         clr_ff   <= (AddrW+1)'(SENSOR_COUNT);
         o_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         clr_ff   <= clr_in;
         o_vld_ff <= o_vld_in;
      end
      kind_ff <= kind_in; sen_ff <= sen_in; hr_ff <= hr_in; smp_ff <= smp_in;
      ohr_ff <= ohr_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
      avg_ff <= avg_in; cat_ff <= cat_in; prod_ff <= prod_in; ov_ff <= ov_in;
      o_kind_ff <= o_kind_in; o_sen_ff <= o_sen_in; o_hr_ff <= o_hr_in;
      o_lvl_ff <= o_lvl_in; o_aqi_ff <= o_aqi_in; o_cat_ff <= o_cat_in;
   end

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff;
      clr_in = clr_ff;
      kind_in = kind_ff; sen_in = sen_ff; hr_in = hr_ff; smp_in = smp_ff;
      ohr_in = ohr_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      avg_in = avg_ff; cat_in = cat_ff; prod_in = prod_ff; ov_in = ov_ff;
      o_kind_in = o_kind_ff; o_sen_in = o_sen_ff; o_hr_in = o_hr_ff;
      o_lvl_in = o_lvl_ff; o_aqi_in = o_aqi_ff; o_cat_in = o_cat_ff;
      o_vld_in = o_vld_ff && rsp_stall;
      ram_we = 1'b0;
      ram_addr = sen_ff[AddrW-1:0];
      ram_wd = '0;
      dreq.start = 1'b0;
      dreq.dividend = DivW'(sum_ff) + DivW'(cnt_ff >> 1);
      dreq.divisor = DivW'(cnt_ff);
      sum_add = {1'b0, sum_ff} + (SumW+1)'(smp_ff);
      q_sat = drsp.quotient;
      aqi_full = (prod_ff + seg_bias(cat_ff)) >> 9;

      if (csr_valid) begin
         unique case (csr_index)
            CsrValidLow:  lo_in = csr_data;
            CsrValidHigh: hi_in = csr_data;
            default: ;
         endcase
      end

      if (clearing) begin
         ram_we   = 1'b1;
         ram_addr = clr_ff[AddrW-1:0] - 1'b1;
         clr_in   = clr_ff - 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_kind; sen_in = req_sensor;
               hr_in = req_hour_of_day; smp_in = req_sample;
               ram_addr = req_sensor[AddrW-1:0];
               if ({24'd0, req_sensor} < 32'(SENSOR_COUNT)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            {ohr_in, sum_in, cnt_in} = ram_rd;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (kind_ff == KindFlush) begin
               if (cnt_ff != '0) begin
                  dreq.start = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (smp_ff < lo_ff || smp_ff > hi_ff) begin
               o_kind_in = RptOutlier; o_sen_in = sen_ff; o_hr_in = hr_ff;
               o_lvl_in = smp_ff; o_aqi_in = '0; o_cat_in = '0;
               o_vld_in = 1'b1;
            end else if (cnt_ff != '0 && ohr_ff != hr_ff) begin
               // close the old hour from the held totals and open the new one
               dreq.start = 1'b1;
               state_in = ST_DIV;
               ram_we = 1'b1;
               ram_wd = {hr_ff, SumW'(smp_ff), CntW'(1)};
            end else if (cnt_ff == '0) begin
               ram_we = 1'b1;
               ram_wd = {hr_ff, SumW'(smp_ff), CntW'(1)};
            end else if ({{(32-CntW){1'b0}}, cnt_ff} < 32'(MAX_PER_HOUR)) begin
               ram_we = 1'b1;
               ram_wd = {ohr_ff, sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0],
                         cnt_ff + 1'b1};
            end
            if (kind_ff == KindFlush && cnt_ff != '0) begin
               ram_we = 1'b1;
               ram_wd = {ohr_ff, {SumW{1'b0}}, {CntW{1'b0}}};
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               ov_in  = (q_sat > DivW'(16383));
               avg_in = ov_in ? 14'h3FFF : q_sat[SampleW-1:0];
               cat_in = seg_of(avg_in);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = ProdW'(seg_slope(cat_ff) * avg_ff);
            state_in = ST_AQI;
         end
         ST_AQI: begin
            // divide by 2560: shift by 9, then by 5 through a reciprocal
            state_in = ST_OUT;
            prod_in = (aqi_full * 32'd52429) >> 18;
         end
         ST_OUT: begin
            o_kind_in = RptAverage; o_sen_in = sen_ff;
            o_hr_in = (ohr_ff >= 5'd23) ? 5'd0 : ohr_ff + 1'b1;
            o_lvl_in = avg_ff; o_cat_in = cat_ff;
            o_aqi_in = (prod_ff > 32'd500) ? 9'd500 : prod_ff[AqiW-1:0];
            o_vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_report_kind = o_kind_ff;
   assign rsp_sensor_out = o_sen_ff;
   assign rsp_hour_label = o_hr_ff;
   assign rsp_level = o_lvl_ff;
   assign rsp_aqi = o_aqi_ff;
   assign rsp_category = o_cat_ff;

   `ASSERT_IMPLIES(a_no_take_clear, clock, reset, clearing, !req_take)
   `ASSERT_IMPLIES(a_outlier_zero, clock, reset,
      o_vld_ff && o_kind_ff == RptOutlier, o_aqi_ff == '0 && o_cat_ff == '0)
   `ASSERT_IMPLIES(a_aqi_max, clock, reset, o_vld_ff, o_aqi_ff <= 9'd500)
   `ASSERT_NEXT(a_div_wait, clock, reset, state_ff == ST_DECIDE && dreq.start,
      drsp.busy)
endmodule

@@ rtl/hdaqi_ram.sv @@
// Generic single-port RAM with registered read.
module hdaqi_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/hdaqi_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module hdaqi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  hdaqi_pkg::div_req_type     req,
   output hdaqi_pkg::div_rsp_type     rsp
);
   import hdaqi_pkg::*;
   `include "assert_macros.svh"

   logic [DivW-1:0] rem_ff, rem_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [DivW-1:0] dvs_ff, dvs_in;
   logic [$clog2(DivW+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DivW:0] trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DivW-1]} - {1'b0, dvs_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = ($clog2(DivW+1))'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the trial difference if it fits
         if (!trial[DivW]) begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivW-2:0], quo_ff[DivW-1]};
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(DivW+1))'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   `ASSERT_NEXT(a_done_after_busy, clock, reset, done_ff, !busy_ff)
   `ASSERT_IMPLIES(a_cnt_idle, clock, reset, !busy_ff, cnt_ff == '0)
   `ASSERT_IMPLIES(a_nonzero_div, clock, reset, busy_ff, dvs_ff != '0)
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the hourly dust AQI reporter.
`timescale 1ns / 1ps
module testbench;
   import hdaqi_pkg::*;

   localparam int IdleLimit = 20000;
   localparam int RandomPerPhase = 275;
   localparam int SumCeiling = 33554431;
   localparam int HourCap = 100;

   typedef struct packed {
      logic [0:0]  kind;
      logic [7:0]  sensor;
      logic [4:0]  hour;
      logic [13:0] sample;
   } dust_item_type;

   typedef struct packed {
      logic [0:0]  report_kind;
      logic [7:0]  sensor;
      logic [4:0]  label;
      logic [13:0] level;
      logic [8:0]  aqi;
      logic [2:0]  category;
   } aqi_report_type;

   typedef struct {
      dust_item_type  item;
      bit             typed;
      aqi_report_type report;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [0:0]  req_kind = KindSample;
   logic [7:0]  req_sensor = '0;
   logic [4:0]  req_hour_of_day = '0;
   logic [13:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [0:0]  rsp_report_kind;
   logic [7:0]  rsp_sensor_out;
   logic [4:0]  rsp_hour_label;
   logic [13:0] rsp_level;
   logic [8:0]  rsp_aqi;
   logic [2:0]  rsp_category;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CsrValidLow;
   logic [13:0] csr_data = '0;

   hourly_dust_aqi_reporter #(.MAX_PER_HOUR(HourCap)) u_top (.*);

   // shadow of the block's per-sensor accumulators and window
   logic [4:0]  acc_hour [256];
   int unsigned acc_sum [256];
   int unsigned acc_count [256];
   int unsigned win_low = 50;
   int unsigned win_high = 5505;

   aqi_report_type reports_due[$];
   int errors = 0;
   int items_sent = 0;
   int reports_seen = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit gaps_on = 1'b1;
   int burst_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic aqi_report_type close_hour(input int unsigned s);
      int unsigned bound [6] = '{120, 355, 555, 1505, 2505, 3505};
      int unsigned slope [7] = '{1067, 543, 640, 133, 256, 256, 128};
      int unsigned offs [7] = '{0, 6262, 2880, 30920, 12672, 12672, 57536};
      longint unsigned avg, aqi;
      int unsigned cat;
      aqi_report_type r;
      avg = (longint'(acc_sum[s]) + acc_count[s] / 2) / acc_count[s];
      if (avg > 16383) avg = 16383;
      cat = 0;
      while (cat < 6 && avg >= bound[cat]) cat++;
      aqi = (slope[cat] * avg + 10 * offs[cat] + 1280) / 2560;
      if (aqi > 500) aqi = 500;
      r.report_kind = RptAverage;
      r.sensor = s[7:0];
      r.label = (acc_hour[s] >= 23) ? 5'd0 : acc_hour[s] + 5'd1;
      r.level = avg[13:0];
      r.aqi = aqi[8:0];
      r.category = cat[2:0];
      acc_sum[s] = 0;
      acc_count[s] = 0;
      return r;
   endfunction

   // advance the shadow state by one item; return whether a report follows
   function automatic bit predict_report(input dust_item_type it,
                                         output aqi_report_type r);
      int unsigned s;
      bit closed;
      longint unsigned t;
      s = it.sensor;
      closed = 1'b0;
      r = '0;
      if (it.kind == KindFlush) begin
         if (acc_count[s] == 0) return 1'b0;
         r = close_hour(s);
         return 1'b1;
      end
      if (it.sample < win_low || it.sample > win_high) begin
         r = '{RptOutlier, it.sensor, it.hour, it.sample, 9'd0, 3'd0};
         return 1'b1;
      end
      if (acc_count[s] != 0 && acc_hour[s] != it.hour) begin
         r = close_hour(s);
         closed = 1'b1;
      end
      if (acc_count[s] == 0) begin
         acc_hour[s] = it.hour;
         acc_sum[s] = it.sample;
         acc_count[s] = 1;
      end else if (acc_count[s] < HourCap) begin
         t = longint'(acc_sum[s]) + it.sample;
         acc_sum[s] = 32'((t > SumCeiling) ? SumCeiling : t);
         acc_count[s]++;
      end
      return closed;
   endfunction

   task automatic send_item(input dust_item_type it, input bit typed,
                            input aqi_report_type typed_r);
      aqi_report_type r;
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_sensor <= it.sensor;
      req_hour_of_day <= it.hour;
      req_sample <= it.sample;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_report(it, r)) reports_due.push_back(typed ? typed_r : r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [13:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrValidLow) win_low = data;
      else win_high = data;
      @(posedge clock);
   endtask

   function automatic dust_item_type random_item();
      dust_item_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      it.kind = (pick < 10) ? KindFlush : KindSample;
      it.sensor = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 5));
      // mostly stay in the sensor's open hour, sometimes move on
      if ($urandom_range(0, 7) == 0)
         it.hour = 5'(($urandom_range(0, 15) == 0) ? $urandom_range(24, 31)
                                                   : $urandom_range(0, 23));
      else
         it.hour = acc_hour[it.sensor];
      if (pick < 20) it.sample = 14'($urandom_range(0, 16383));
      else if (pick < 30) it.sample = 14'($urandom_range(0, 120));
      else it.sample = 14'($urandom_range(50, 5505));
      return it;
   endfunction

   // receiver stall pattern: hold each level for a random stretch
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin
      aqi_report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (reports_due.size() == 0) begin
            $error("report with none expected: sensor %0d", rsp_sensor_out);
            errors++;
         end else begin
            e = reports_due.pop_front();
            if (rsp_report_kind != e.report_kind) begin
               $error("report_kind: expected %0d, got %0d", e.report_kind, rsp_report_kind);
               errors++;
            end
            if (rsp_sensor_out != e.sensor) begin
               $error("sensor_out: expected %0d, got %0d", e.sensor, rsp_sensor_out);
               errors++;
            end
            if (rsp_hour_label != e.label) begin
               $error("hour_label: expected %0d, got %0d", e.label, rsp_hour_label);
               errors++;
            end
            if (rsp_level != e.level) begin
               $error("level: expected %0d, got %0d", e.level, rsp_level);
               errors++;
            end
            if (rsp_aqi != e.aqi) begin
               $error("aqi: expected %0d, got %0d", e.aqi, rsp_aqi);
               errors++;
            end
            if (rsp_category != e.category) begin
               $error("category: expected %0d, got %0d", e.category, rsp_category);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no progress for %0d cycles", IdleLimit);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   directed_row_type plan [] = '{
      '{'{KindSample, 8'd3, 5'd5, 14'd49}, 1'b1, '{RptOutlier, 8'd3, 5'd5, 14'd49, 9'd0, 3'd0}},
      '{'{KindSample, 8'd3, 5'd5, 14'd5506}, 1'b1,
        '{RptOutlier, 8'd3, 5'd5, 14'd5506, 9'd0, 3'd0}},
      '{'{KindSample, 8'd3, 5'd5, 14'd0}, 1'b1, '{RptOutlier, 8'd3, 5'd5, 14'd0, 9'd0, 3'd0}},
      '{'{KindSample, 8'd3, 5'd31, 14'd16383}, 1'b1,
        '{RptOutlier, 8'd3, 5'd31, 14'd16383, 9'd0, 3'd0}},
      '{'{KindFlush, 8'd9, 5'd4, 14'd700}, 1'b0, '0},
      '{'{KindSample, 8'd4, 5'd5, 14'd120}, 1'b0, '0},
      '{'{KindFlush, 8'd4, 5'd0, 14'd0}, 1'b1, '{RptAverage, 8'd4, 5'd6, 14'd120, 9'd50, 3'd1}},
      '{'{KindSample, 8'd1, 5'd23, 14'd5505}, 1'b0, '0},
      '{'{KindFlush, 8'd1, 5'd0, 14'd0}, 1'b1, '{RptAverage, 8'd1, 5'd0, 14'd5505, 9'd500, 3'd6}},
      '{'{KindSample, 8'd2, 5'd0, 14'd50}, 1'b0, '0},
      '{'{KindFlush, 8'd2, 5'd31, 14'd16383}, 1'b1,
        '{RptAverage, 8'd2, 5'd1, 14'd50, 9'd21, 3'd0}},
      '{'{KindSample, 8'd255, 5'd10, 14'd354}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd10, 14'd356}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd11, 14'd554}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd12, 14'd1504}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd13, 14'd2504}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd14, 14'd3504}, 1'b0, '0},
      '{'{KindSample, 8'd255, 5'd15, 14'd3505}, 1'b0, '0},
      '{'{KindSample, 8'd0, 5'd31, 14'd200}, 1'b0, '0},
      '{'{KindSample, 8'd0, 5'd31, 14'd201}, 1'b0, '0},
      '{'{KindFlush, 8'd0, 5'd0, 14'd0}, 1'b0, '0},
      '{'{KindFlush, 8'd255, 5'd0, 14'd0}, 1'b0, '0}
   };

   int unsigned lows [5] = '{50, 0, 16383, 0, 50};
   int unsigned highs [5] = '{5505, 16383, 0, 0, 5505};

   initial begin
      dust_item_type it;
      for (int i = 0; i < 256; i++) begin
         acc_hour[i] = '0;
         acc_sum[i] = 0;
         acc_count[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].report);
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p == 3) begin
            lows[3] = $urandom_range(0, 600);
            highs[3] = $urandom_range(2000, 16383);
         end
         write_reg(CsrValidLow, 14'(lows[p]));
         write_reg(CsrValidHigh, 14'(highs[p]));
         gaps_on = (p != 1);
         repeat (RandomPerPhase) send_item(random_item(), 1'b0, '0);
         drain();
      end

      // fill one hour past the count cap
      write_reg(CsrValidLow, 14'd0);
      write_reg(CsrValidHigh, 14'd16383);
      gaps_on = 1'b0;
      repeat (HourCap + 5) send_item('{KindSample, 8'd7, 5'd3, 14'd16383}, 1'b0, '0);
      send_item('{KindFlush, 8'd7, 5'd0, 14'd0}, 1'b0, '0);
      drain();

      $display("covered %0d items and %0d reports over six window settings,", items_sent,
               reports_seen);
      $display("including outliers, hour changes, flushes, empty window and a full hour");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
